@@ rtl/axis_angle_rotate_vector_unit_assert.svh @@
// ----------------------------------------------------------------------------
// axis angle rotate vector unit assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_ROTATE_VECTOR_UNIT_ASSERT_SVH
`define AXIS_ANGLE_ROTATE_VECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define AVR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("avr assertion failed");
`define AVR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("avr assertion failed");
`else
`define AVR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AVR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/avr_pkg.sv @@
// ----------------------------------------------------------------------------
// avr_pkg
// shared constants, codes and types of the axis angle rotate vector unit
// ----------------------------------------------------------------------------
package avr_pkg;

   localparam int AXIS_W       = 15;
   localparam int ANGLE_W      = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int AXIS_FRAC    = 14;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = 4;
   localparam int CORDIC_W     = 34;
   localparam int ANGLE_Z_W    = 26;
   localparam int NUM_COEFS    = 9;
   localparam int COEF_IDX_W   = 4;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_X = 2'd0,
      CSR_AXIS_Y = 2'd1,
      CSR_AXIS_Z = 2'd2,
      CSR_ANGLE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_X = 2'd0,
      SEL_Y = 2'd1,
      SEL_Z = 2'd2
   } axis_sel_type;

   // one matrix entry: a*b*(1-c) +/- k*s (+ c on the diagonal)
   typedef struct packed {
      axis_sel_type a;
      axis_sel_type b;
      axis_sel_type k;
      logic         sub;
      logic         diag;
   } coef_term_type;

   typedef struct packed {
      logic en1;
      logic en2;
   } lane_ctrl_type;

   function automatic logic signed [ANGLE_Z_W-1:0] atan_turns(logic [STEP_W-1:0] i);
      logic signed [ANGLE_Z_W-1:0] v;
      unique case (i)
         4'd0:  v = 26'sd2097152;
         4'd1:  v = 26'sd1238021;
         4'd2:  v = 26'sd654136;
         4'd3:  v = 26'sd332050;
         4'd4:  v = 26'sd166669;
         4'd5:  v = 26'sd83416;
         4'd6:  v = 26'sd41718;
         4'd7:  v = 26'sd20860;
         4'd8:  v = 26'sd10430;
         4'd9:  v = 26'sd5215;
         4'd10: v = 26'sd2608;
         4'd11: v = 26'sd1304;
         4'd12: v = 26'sd652;
         4'd13: v = 26'sd326;
         4'd14: v = 26'sd163;
         4'd15: v = 26'sd81;
      endcase
      return v;
   endfunction

   // column-major entry layout of the axis-angle matrix
   function automatic coef_term_type coef_term(logic [COEF_IDX_W-1:0] idx);
      coef_term_type t;
      unique case (idx)
         4'd0:    t = '{a: SEL_X, b: SEL_X, k: SEL_X, sub: 1'b0, diag: 1'b1};
         4'd1:    t = '{a: SEL_Y, b: SEL_X, k: SEL_Z, sub: 1'b0, diag: 1'b0};
         4'd2:    t = '{a: SEL_X, b: SEL_Z, k: SEL_Y, sub: 1'b1, diag: 1'b0};
         4'd3:    t = '{a: SEL_X, b: SEL_Y, k: SEL_Z, sub: 1'b1, diag: 1'b0};
         4'd4:    t = '{a: SEL_Y, b: SEL_Y, k: SEL_X, sub: 1'b0, diag: 1'b1};
         4'd5:    t = '{a: SEL_Y, b: SEL_Z, k: SEL_X, sub: 1'b0, diag: 1'b0};
         4'd6:    t = '{a: SEL_X, b: SEL_Z, k: SEL_Y, sub: 1'b0, diag: 1'b0};
         4'd7:    t = '{a: SEL_Y, b: SEL_Z, k: SEL_X, sub: 1'b1, diag: 1'b0};
         4'd8:    t = '{a: SEL_Z, b: SEL_Z, k: SEL_X, sub: 1'b0, diag: 1'b1};
         default: t = '{a: SEL_X, b: SEL_X, k: SEL_X, sub: 1'b0, diag: 1'b0};
      endcase
      return t;
   endfunction

endpackage

@@ rtl/avr_req_if.sv @@
// ----------------------------------------------------------------------------
// avr_req_if
// request channel carrying one homogeneous input vector
// ----------------------------------------------------------------------------
interface avr_req_if #(parameter int VECTOR_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [VECTOR_WIDTH-1:0] vec_x;
   logic signed [VECTOR_WIDTH-1:0] vec_y;
   logic signed [VECTOR_WIDTH-1:0] vec_z;
   logic signed [VECTOR_WIDTH-1:0] vec_w;

   modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
   modport sink (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

@@ rtl/avr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// avr_rsp_if
// response channel carrying one rotated vector
// ----------------------------------------------------------------------------
interface avr_rsp_if #(parameter int VECTOR_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [VECTOR_WIDTH-1:0] out_x;
   logic signed [VECTOR_WIDTH-1:0] out_y;
   logic signed [VECTOR_WIDTH-1:0] out_z;
   logic signed [VECTOR_WIDTH-1:0] out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

@@ rtl/avr_matrix_build.sv @@
// ----------------------------------------------------------------------------
// avr_matrix_build
// holds the config registers; on each write runs an iterative cordic for
// sine and cosine and then builds the nine matrix entries one at a time
// ----------------------------------------------------------------------------
module avr_matrix_build #(
   parameter int COEF_WIDTH = 18
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [avr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [avr_pkg::CSR_DATA_W-1:0]         csr_wr_data,
   output logic                                   busy,
   output logic signed [COEF_WIDTH-1:0]           coefs [avr_pkg::NUM_COEFS]
);

   localparam int COEF_FRAC = COEF_WIDTH - 4;
   localparam int CS_W      = COEF_FRAC + 3;
   localparam int OMC_W     = CS_W + 1;
   localparam int RND_SH    = 30 - COEF_FRAC;
   localparam int P1_W      = 2 * avr_pkg::AXIS_W;
   localparam int P2_W      = avr_pkg::AXIS_W + CS_W;
   localparam int T1_W      = P1_W + OMC_W;
   localparam int T2_W      = P2_W + 1;
   localparam int SUM_W     = T1_W + 3;
   localparam int RES_W     = SUM_W - 2 * avr_pkg::AXIS_FRAC;
   localparam int CW        = avr_pkg::CORDIC_W;
   localparam int ZW        = avr_pkg::ANGLE_Z_W;
   localparam int AW        = avr_pkg::AXIS_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CORDIC = 4'b0010,
      ST_QUAD   = 4'b0100,
      ST_MAT    = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      PH_MUL   = 2'd0,
      PH_SCALE = 2'd1,
      PH_SUM   = 2'd2
   } phase_type;

   state_type                             state_ff, state_in;
   phase_type                             phase_ff, phase_in;
   logic signed [AW-1:0]                  axis_x_ff, axis_x_in;
   logic signed [AW-1:0]                  axis_y_ff, axis_y_in;
   logic signed [AW-1:0]                  axis_z_ff, axis_z_in;
   logic [avr_pkg::ANGLE_W-1:0]           angle_ff, angle_in;
   logic [avr_pkg::STEP_W-1:0]            step_ff, step_in;
   logic signed [CW-1:0]                  cx_ff, cx_in;
   logic signed [CW-1:0]                  cy_ff, cy_in;
   logic signed [ZW-1:0]                  z_ff, z_in;
   logic [1:0]                            quad_ff, quad_in;
   logic signed [CS_W-1:0]                c_ff, c_in;
   logic signed [CS_W-1:0]                s_ff, s_in;
   logic signed [OMC_W-1:0]               omc_ff, omc_in;
   logic [avr_pkg::COEF_IDX_W-1:0]        idx_ff, idx_in;
   logic signed [P1_W-1:0]                p1_ff, p1_in;
   logic signed [P2_W-1:0]                p2_ff, p2_in;
   logic signed [T1_W-1:0]                t1_ff, t1_in;
   logic signed [T2_W-1:0]                t2_ff, t2_in;
   logic signed [COEF_WIDTH-1:0]          coef_ff [avr_pkg::NUM_COEFS];
   logic signed [COEF_WIDTH-1:0]          coef_in;
   logic                                  coef_we;

   logic [avr_pkg::ANGLE_W-1:0]           angle_new;
   logic [avr_pkg::ANGLE_W:0]             angle_off;
   logic signed [CW-1:0]                  sx, sy;
   logic signed [CS_W-1:0]                cr, sr;
   logic signed [SUM_W-1:0]               sum;
   logic signed [RES_W-1:0]               rnd;
   avr_pkg::coef_term_type                term;

   localparam logic signed [RES_W-1:0] CMAX = (RES_W'(1) <<< (COEF_WIDTH - 1)) - RES_W'(1);
   localparam logic signed [RES_W-1:0] CMIN = -(RES_W'(1) <<< (COEF_WIDTH - 1));

   function automatic logic signed [AW-1:0] pick(avr_pkg::axis_sel_type s,
                                                 logic signed [AW-1:0] x,
                                                 logic signed [AW-1:0] y,
                                                 logic signed [AW-1:0] z);
      logic signed [AW-1:0] v;
      unique case (s)
         avr_pkg::SEL_X: v = x;
         avr_pkg::SEL_Y: v = y;
         default:        v = z;
      endcase
      return v;
   endfunction

   assign term = avr_pkg::coef_term(idx_ff);
   assign busy = (state_ff != ST_IDLE);
   assign coefs = coef_ff;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      axis_x_in = axis_x_ff;
      axis_y_in = axis_y_ff;
      axis_z_in = axis_z_ff;
      angle_in  = angle_ff;
      step_in   = step_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      z_in      = z_ff;
      quad_in   = quad_ff;
      c_in      = c_ff;
      s_in      = s_ff;
      omc_in    = omc_ff;
      idx_in    = idx_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      coef_we   = 1'b0;

      angle_new = (csr_wr_en && csr_index == avr_pkg::CSR_ANGLE) ? csr_wr_data : angle_ff;
      // quadrant and residual in [-1/8, 1/8) turn
      angle_off = {1'b0, angle_new} + 17'd8192;

      sx = cx_ff >>> step_ff;
      sy = cy_ff >>> step_ff;
      cr = CS_W'((cx_ff + (CW'(1) <<< (RND_SH - 1))) >>> RND_SH);
      sr = CS_W'((cy_ff + (CW'(1) <<< (RND_SH - 1))) >>> RND_SH);

      sum = SUM_W'(t1_ff) + (SUM_W'(t2_ff) <<< avr_pkg::AXIS_FRAC)
          + (term.diag ? (SUM_W'(c_ff) <<< (2 * avr_pkg::AXIS_FRAC)) : SUM_W'(0))
          + (SUM_W'(1) <<< (2 * avr_pkg::AXIS_FRAC - 1));
      rnd = RES_W'(sum >>> (2 * avr_pkg::AXIS_FRAC));
      if (rnd > CMAX) begin
         coef_in = COEF_WIDTH'(CMAX);
      end else if (rnd < CMIN) begin
         coef_in = COEF_WIDTH'(CMIN);
      end else begin
         coef_in = COEF_WIDTH'(rnd);
      end

      unique case (state_ff)
         ST_CORDIC: begin
            if (!z_ff[ZW-1]) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               z_in  = z_ff - avr_pkg::atan_turns(step_ff);
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               z_in  = z_ff + avr_pkg::atan_turns(step_ff);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == avr_pkg::STEP_W'(avr_pkg::CORDIC_STEPS - 1)) begin
               state_in = ST_QUAD;
            end
         end
         ST_QUAD: begin
            unique case (quad_ff)
               2'd0: begin c_in = cr;  s_in = sr;  end
               2'd1: begin c_in = -sr; s_in = cr;  end
               2'd2: begin c_in = -cr; s_in = -sr; end
               2'd3: begin c_in = sr;  s_in = -cr; end
            endcase
            omc_in   = (OMC_W'(1) <<< COEF_FRAC) - OMC_W'(c_in);
            idx_in   = '0;
            phase_in = PH_MUL;
            state_in = ST_MAT;
         end
         ST_MAT: begin
            unique case (phase_ff)
               PH_MUL: begin
                  p1_in = P1_W'(pick(term.a, axis_x_ff, axis_y_ff, axis_z_ff))
                        * P1_W'(pick(term.b, axis_x_ff, axis_y_ff, axis_z_ff));
                  p2_in = P2_W'(pick(term.k, axis_x_ff, axis_y_ff, axis_z_ff)) * P2_W'(s_ff);
                  phase_in = PH_SCALE;
               end
               PH_SCALE: begin
                  t1_in = T1_W'(p1_ff) * T1_W'(omc_ff);
                  // diagonal entries carry no sine term
                  if (term.diag) begin
                     t2_in = '0;
                  end else begin
                     t2_in = term.sub ? -T2_W'(p2_ff) : T2_W'(p2_ff);
                  end
                  phase_in = PH_SUM;
               end
               PH_SUM: begin
                  coef_we  = 1'b1;
                  phase_in = PH_MUL;
                  idx_in   = idx_ff + 1'b1;
                  if (idx_ff == avr_pkg::COEF_IDX_W'(avr_pkg::NUM_COEFS - 1)) begin
                     state_in = ST_IDLE;
                  end
               end
               default: phase_in = PH_MUL;
            endcase
         end
         default: ;
      endcase

      if (csr_wr_en) begin
         unique case (avr_pkg::csr_index_type'(csr_index))
            avr_pkg::CSR_AXIS_X: axis_x_in = csr_wr_data[AW-1:0];
            avr_pkg::CSR_AXIS_Y: axis_y_in = csr_wr_data[AW-1:0];
            avr_pkg::CSR_AXIS_Z: axis_z_in = csr_wr_data[AW-1:0];
            avr_pkg::CSR_ANGLE:  angle_in  = csr_wr_data;
         endcase
         state_in = ST_CORDIC;
         step_in  = '0;
         cx_in    = avr_pkg::CORDIC_GAIN_Q30;
         cy_in    = '0;
         quad_in  = angle_off[15:14];
         z_in     = ZW'($signed({1'b0, angle_off[13:0]}) - 16'sd8192) <<< 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         axis_x_ff <= '0;
         axis_y_ff <= '0;
         axis_z_ff <= AW'(16383);
         angle_ff  <= '0;
         for (int i = 0; i < avr_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= (i % 4 == 0) ? (COEF_WIDTH'(1) <<< COEF_FRAC) : '0;
         end
      end else begin
         state_ff  <= state_in;
         axis_x_ff <= axis_x_in;
         axis_y_ff <= axis_y_in;
         axis_z_ff <= axis_z_in;
         angle_ff  <= angle_in;
         if (coef_we) begin
            coef_ff[idx_ff] <= coef_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      step_ff  <= step_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      z_ff     <= z_in;
      quad_ff  <= quad_in;
      c_ff     <= c_in;
      s_ff     <= s_in;
      omc_ff   <= omc_in;
      idx_ff   <= idx_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
   end

endmodule

@@ rtl/avr_lane.sv @@
// ----------------------------------------------------------------------------
// avr_lane
// one output row: three coefficient products split into high and low
// vector parts, summed, then rounded and saturated
// ----------------------------------------------------------------------------
module avr_lane #(
   parameter int VECTOR_WIDTH = 32,
   parameter int COEF_WIDTH   = 18
) (
   input  logic                             clock,
   input  avr_pkg::lane_ctrl_type           ctrl,
   input  logic signed [VECTOR_WIDTH-1:0]   vec  [3],
   input  logic signed [COEF_WIDTH-1:0]     coef [3],
   output logic signed [VECTOR_WIDTH-1:0]   res
);

   localparam int COEF_FRAC = COEF_WIDTH - 4;
   localparam int VH_W  = (VECTOR_WIDTH > 25) ? VECTOR_WIDTH - 24 : 2;
   localparam int VL_W  = 25;
   localparam int PH_W  = COEF_WIDTH + VH_W;
   localparam int PL_W  = COEF_WIDTH + VL_W;
   localparam int HI_W  = PH_W + 2;
   localparam int LO_W  = PL_W + 2;
   localparam int HS_W  = (HI_W + 1 > 42) ? HI_W + 1 : 42;
   localparam int RA_W  = HS_W + 25 - COEF_FRAC;
   localparam int RES_W = (RA_W > VECTOR_WIDTH + 1) ? RA_W : VECTOR_WIDTH + 1;

   localparam logic signed [HS_W-1:0]  LIM  = HS_W'(1) <<< 40;
   localparam logic signed [RES_W-1:0] VMAX = (RES_W'(1) <<< (VECTOR_WIDTH - 1)) - RES_W'(1);
   localparam logic signed [RES_W-1:0] VMIN = -(RES_W'(1) <<< (VECTOR_WIDTH - 1));

   logic signed [PH_W-1:0]              ph_ff [3];
   logic signed [PL_W-1:0]              pl_ff [3];
   logic signed [HI_W-1:0]              hi_ff;
   logic signed [LO_W-1:0]              lo_ff;
   logic signed [VECTOR_WIDTH+23:0]     vs    [3];
   logic signed [VH_W-1:0]              vh    [3];
   logic signed [VL_W-1:0]              vl    [3];
   logic signed [HS_W-1:0]              hs, hc;
   logic [24:0]                         lr_rnd;
   logic signed [RES_W-1:0]             acc;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vs[k] = (VECTOR_WIDTH + 24)'(vec[k]);
         vh[k] = vs[k][24 +: VH_W];
         vl[k] = $signed({1'b0, vs[k][23:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en1) begin
         for (int k = 0; k < 3; k++) begin
            ph_ff[k] <= PH_W'(coef[k]) * PH_W'(vh[k]);
            pl_ff[k] <= PL_W'(coef[k]) * PL_W'(vl[k]);
         end
      end
      if (ctrl.en2) begin
         hi_ff <= HI_W'(ph_ff[0]) + HI_W'(ph_ff[1]) + HI_W'(ph_ff[2]);
         lo_ff <= LO_W'(pl_ff[0]) + LO_W'(pl_ff[1]) + LO_W'(pl_ff[2]);
      end
   end

   // carry the low sum's upper part into the high sum, clamp, then round and saturate
   always_comb begin
      hs = HS_W'(hi_ff) + HS_W'(lo_ff >>> 24);
      if (hs > LIM) begin
         hc = LIM;
      end else if (hs < -LIM) begin
         hc = -LIM;
      end else begin
         hc = hs;
      end
      lr_rnd = {1'b0, lo_ff[23:0]} + (25'd1 << (COEF_FRAC - 1));
      acc = (RES_W'(hc) <<< (24 - COEF_FRAC)) + RES_W'($signed({1'b0, lr_rnd >> COEF_FRAC}));
      if (acc > VMAX) begin
         res = VECTOR_WIDTH'(VMAX);
      end else if (acc < VMIN) begin
         res = VECTOR_WIDTH'(VMIN);
      end else begin
         res = VECTOR_WIDTH'(acc);
      end
   end

endmodule

@@ rtl/axis_angle_rotate_vector_unit.sv @@
// a request passes the lane product, lane sum and output registers in turn
// throughput: one request per cycle, set by the three-stage pipeline, unless back-pressure
// or a rebuild holds it; each config write rebuilds the matrix by 16 cordic steps, a
// quadrant step, multiply, scale and sum per entry; requests are held off during the rebuild
// reset: synchronous, clears the pipeline and loads the identity matrix
// ----------------------------------------------------------------------------
// axis_angle_rotate_vector_unit
// rotates homogeneous q16.16 vectors by a configured axis-angle matrix
// ----------------------------------------------------------------------------
`include "axis_angle_rotate_vector_unit_assert.svh"

module axis_angle_rotate_vector_unit #(
   parameter int VECTOR_WIDTH = 32,
   parameter int COEF_WIDTH   = 18
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [avr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [avr_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   avr_req_if.sink                            req_if,
   avr_rsp_if.source                          rsp_if
);

   logic                             build_busy;
   logic signed [COEF_WIDTH-1:0]     coefs [avr_pkg::NUM_COEFS];
   logic signed [VECTOR_WIDTH-1:0]   vec_in [3];
   logic signed [VECTOR_WIDTH-1:0]   lane_res [3];
   avr_pkg::lane_ctrl_type           ctrl;
   logic                             en_out;
   logic                             v1_ff, v2_ff, rsp_valid_ff;
   logic signed [VECTOR_WIDTH-1:0]   w1_ff, w2_ff;
   logic signed [VECTOR_WIDTH-1:0]   out_ff [4];

   avr_matrix_build #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_build (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .busy        (build_busy),
      .coefs       (coefs)
   );

   // each stage moves when the one after it is empty or moving
   assign en_out   = !rsp_valid_ff || rsp_if.ready;
   assign ctrl.en2 = !v2_ff || en_out;
   assign ctrl.en1 = !v1_ff || ctrl.en2;
   assign req_if.ready = ctrl.en1 && !build_busy;

   assign vec_in[0] = req_if.vec_x;
   assign vec_in[1] = req_if.vec_y;
   assign vec_in[2] = req_if.vec_z;

   for (genvar r = 0; r < 3; r++) begin : g_lane
      logic signed [COEF_WIDTH-1:0] row_coef [3];
      assign row_coef[0] = coefs[r];
      assign row_coef[1] = coefs[3 + r];
      assign row_coef[2] = coefs[6 + r];

      avr_lane #(
         .VECTOR_WIDTH (VECTOR_WIDTH),
         .COEF_WIDTH   (COEF_WIDTH)
      ) u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .vec   (vec_in),
         .coef  (row_coef),
         .res   (lane_res[r])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.en1) begin
            v1_ff <= req_if.valid && req_if.ready;
         end
         if (ctrl.en2) begin
            v2_ff <= v1_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   // merge the lane rows with the pass-through w
   always_ff @(posedge clock) begin
      if (ctrl.en1) begin
         w1_ff <= req_if.vec_w;
      end
      if (ctrl.en2) begin
         w2_ff <= w1_ff;
      end
      if (en_out) begin
         out_ff[0] <= lane_res[0];
         out_ff[1] <= lane_res[1];
         out_ff[2] <= lane_res[2];
         out_ff[3] <= w2_ff;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_x = out_ff[0];
   assign rsp_if.out_y = out_ff[1];
   assign rsp_if.out_z = out_ff[2];
   assign rsp_if.out_w = out_ff[3];

   `AVR_ASSERT_IMP(a_no_req_during_build, clock, reset, req_if.valid && req_if.ready, !build_busy)
   `AVR_ASSERT_NEXT(a_write_starts_build, clock, reset, csr_wr_en, build_busy)
   `AVR_ASSERT_NEXT(a_stage2_reaches_out, clock, reset, v2_ff && en_out, rsp_valid_ff)

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives random and directed homogeneous vectors through the axis angle
// rotate vector unit under several axis and angle settings, predicts each
// rotated vector from its own cordic and matrix model and checks every response
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
   } vec4_type;

   class rotation_scoreboard;
      logic [14:0] axis[3];
      logic [15:0] angle;
      longint      coef[9];
      vec4_type    rotated_q[$];
      int          errors;

      function new();
         axis[0] = 15'd0;
         axis[1] = 15'd0;
         axis[2] = 15'd16383;
         angle   = 16'd0;
         errors  = 0;
         foreach (coef[i]) coef[i] = (i % 4 == 0) ? 64'sd16384 : 64'sd0;
      endfunction

      function longint clamp(longint v, int w);
         longint hi, lo;
         hi = (64'sd1 <<< (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void rebuild();
         longint atan_tab[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                  41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                  163, 81};
         longint a17, zr, cx, cy, nx, c, s, t, omc, ax, ay, az;
         longint m[9];
         int     q;
         a17 = longint'(angle) + 8192;
         q   = int'((a17 >> 14) & 3);
         zr  = ((a17 & 16383) - 8192) * 256;
         cx  = 652032874;
         cy  = 0;
         for (int i = 0; i < 16; i++) begin
            if (zr >= 0) begin
               nx = cx - (cy >>> i);
               cy = cy + (cx >>> i);
               zr -= atan_tab[i];
            end else begin
               nx = cx + (cy >>> i);
               cy = cy - (cx >>> i);
               zr += atan_tab[i];
            end
            cx = nx;
         end
         c = (cx + (64'sd1 <<< 15)) >>> 16;
         s = (cy + (64'sd1 <<< 15)) >>> 16;
         if (q == 1) begin
            t = c; c = -s; s = t;
         end else if (q == 2) begin
            c = -c; s = -s;
         end else if (q == 3) begin
            t = c; c = s; s = -t;
         end
         omc = 16384 - c;
         ax = longint'($signed(axis[0]));
         ay = longint'($signed(axis[1]));
         az = longint'($signed(axis[2]));
         m[0] = ax * ax * omc + c * 268435456;
         m[1] = ay * ax * omc + az * s * 16384;
         m[2] = ax * az * omc - ay * s * 16384;
         m[3] = ax * ay * omc - az * s * 16384;
         m[4] = ay * ay * omc + c * 268435456;
         m[5] = ay * az * omc + ax * s * 16384;
         m[6] = ax * az * omc + ay * s * 16384;
         m[7] = ay * az * omc - ax * s * 16384;
         m[8] = az * az * omc + c * 268435456;
         foreach (m[i]) coef[i] = clamp((m[i] + (64'sd1 <<< 27)) >>> 28, 18);
      endfunction

      function void write_register(avr_pkg::csr_index_type idx, logic [15:0] data);
         unique case (idx)
            avr_pkg::CSR_AXIS_X: axis[0] = data[14:0];
            avr_pkg::CSR_AXIS_Y: axis[1] = data[14:0];
            avr_pkg::CSR_AXIS_Z: axis[2] = data[14:0];
            avr_pkg::CSR_ANGLE:  angle   = data;
         endcase
         rebuild();
      endfunction

      function void note_request(vec4_type v);
         longint vh[3], vl[3], hi, lo, lq, lr, res, val;
         logic [31:0] comp[3];
         logic [31:0] rot[3];
         vec4_type e;
         comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
         for (int k = 0; k < 3; k++) begin
            val   = longint'($signed(comp[k]));
            vh[k] = val >>> 24;
            vl[k] = val & 64'hFF_FFFF;
         end
         for (int r = 0; r < 3; r++) begin
            hi = 0;
            lo = 0;
            for (int k = 0; k < 3; k++) begin
               hi += coef[k * 3 + r] * vh[k];
               lo += coef[k * 3 + r] * vl[k];
            end
            lq = lo >>> 24;
            lr = lo - lq * 16777216;
            hi += lq;
            if (hi > (64'sd1 <<< 40)) hi = 64'sd1 <<< 40;
            if (hi < -(64'sd1 <<< 40)) hi = -(64'sd1 <<< 40);
            res = hi * 1024 + ((lr + 8192) >>> 14);
            rot[r] = 32'(clamp(res, 32));
         end
         e.x = rot[0]; e.y = rot[1]; e.z = rot[2]; e.w = v.w;
         rotated_q.push_back(e);
      endfunction

      function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(vec4_type act);
         vec4_type e;
         if (rotated_q.size() == 0) begin
            $display("%0t unexpected response expected none actual %h %h %h %h",
                     $time, act.x, act.y, act.z, act.w);
            errors++;
            return;
         end
         e = rotated_q.pop_front();
         compare("out_x", e.x, act.x);
         compare("out_y", e.y, act.y);
         compare("out_z", e.z, act.z);
         compare("out_w", e.w, act.w);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   avr_pkg::csr_index_type csr_index;
   logic [15:0] csr_wr_data;
   bit squeeze = 1'b0;
   rotation_scoreboard sb;

   avr_req_if #(.VECTOR_WIDTH(32)) req ();
   avr_rsp_if #(.VECTOR_WIDTH(32)) rsp ();

   axis_angle_rotate_vector_unit uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_if      (req),
      .rsp_if      (rsp)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_vector(vec4_type v, int gap);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.vec_x <= v.x;
      req.vec_y <= v.y;
      req.vec_z <= v.z;
      req.vec_w <= v.w;
      do @(posedge clock); while (!req.ready);
      sb.note_request(v);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (sb.rotated_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // the unit rebuilds its matrix after each write, hold off until it is done
   task automatic write_csr(avr_pkg::csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_register(idx, data);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_comp();
      logic [31:0] extremes[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                                   32'h0080_0000, 32'hFF00_0000};
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom;
      if (r < 9) return $unsigned(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      return extremes[$urandom_range(0, 5)];
   endfunction

   function automatic logic [15:0] rand_axis();
      logic [15:0] picks[5] = '{16'h3FFF, 16'h4000, 16'h0000, 16'h2D41, 16'h52BF};
      logic [15:0] v;
      v = ($urandom_range(0, 1) == 0) ? picks[$urandom_range(0, 4)] : 16'($urandom);
      // upper bit is not part of the register
      v[15] = $urandom_range(0, 1);
      return v;
   endfunction

   function automatic logic [15:0] rand_angle();
      logic [15:0] picks[8] = '{16'd0, 16'd8191, 16'd8192, 16'd16384, 16'd24576,
                                16'd32768, 16'd49152, 16'd65535};
      if ($urandom_range(0, 9) < 4) return picks[$urandom_range(0, 7)];
      return 16'($urandom);
   endfunction

   // response side: random back-pressure, one long hold when asked
   initial begin
      int stall;
      vec4_type act;
      forever begin
         if (squeeze) begin
            stall   = 200;
            squeeze = 1'b0;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) begin
            @(posedge clock);
            if (rsp.valid && rsp.ready) begin
               act.x = rsp.out_x; act.y = rsp.out_y;
               act.z = rsp.out_z; act.w = rsp.out_w;
               sb.check_response(act);
            end
         end
      end
   end

   initial begin
      vec4_type directed[$];
      vec4_type v;
      logic [31:0] d[9] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'h0000_0001, 32'h0001_0000, 32'h00FF_FFFF, 32'hFF00_0000,
                            32'h0080_0000};
      bit burst;
      sb = new();
      csr_wr_en   <= 1'b0;
      csr_index   <= avr_pkg::CSR_AXIS_X;
      csr_wr_data <= 16'h0;
      req.valid   <= 1'b0;
      req.vec_x   <= 32'h0;
      req.vec_y   <= 32'h0;
      req.vec_z   <= 32'h0;
      req.vec_w   <= 32'h0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (60) @(posedge clock);

      foreach (d[i]) begin
         v.x = d[i]; v.y = d[(i + 3) % 9]; v.z = d[(i + 6) % 9]; v.w = d[(i + 1) % 9];
         directed.push_back(v);
      end
      v.x = 32'h7FFF_FFFF; v.y = 32'h7FFF_FFFF; v.z = 32'h7FFF_FFFF; v.w = 32'h8000_0000;
      directed.push_back(v);
      v.x = 32'h8000_0000; v.y = 32'h8000_0000; v.z = 32'h8000_0000; v.w = 32'h7FFF_FFFF;
      directed.push_back(v);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 1) begin
            // oversized axis
            write_csr(avr_pkg::CSR_AXIS_X, 16'hC000);
            write_csr(avr_pkg::CSR_AXIS_Y, 16'h3FFF);
            write_csr(avr_pkg::CSR_AXIS_Z, 16'h4000);
            write_csr(avr_pkg::CSR_ANGLE, 16'hFFFF);
         end else if (phase == 2) begin
            write_csr(avr_pkg::CSR_AXIS_X, 16'h0000);
            write_csr(avr_pkg::CSR_AXIS_Y, 16'h8000);
            write_csr(avr_pkg::CSR_AXIS_Z, 16'h0000);
            write_csr(avr_pkg::CSR_ANGLE, 16'h8000);
         end else if (phase > 2) begin
            write_csr(avr_pkg::CSR_AXIS_X, rand_axis());
            write_csr(avr_pkg::CSR_AXIS_Y, rand_axis());
            write_csr(avr_pkg::CSR_AXIS_Z, rand_axis());
            write_csr(avr_pkg::CSR_ANGLE, rand_angle());
         end
         if (phase == 3) squeeze = 1'b1;
         burst = (phase == 3) || (phase == 6);
         if (phase < 3)
            foreach (directed[i]) send_vector(directed[i], burst ? 0 : pick_gap());
         repeat (phase == 0 ? 20 : 165) begin
            v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp(); v.w = $urandom;
            send_vector(v, burst ? 0 : pick_gap());
         end
         wait_idle();
      end

      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/avr_pkg.sv
rtl/avr_req_if.sv
rtl/avr_rsp_if.sv
rtl/avr_matrix_build.sv
rtl/avr_lane.sv
rtl/axis_angle_rotate_vector_unit.sv
test/tb_top.sv
